>>> rtl/core/uusplit_pkg.sv
// ----------------------------------------------------------------------------
// UUniFast utilization split package
// Shared types and constants for the utilization splitter.
// ----------------------------------------------------------------------------
package uusplit_pkg;

    localparam int unsigned IDX_TASK_COUNT = 0;
    localparam int unsigned IDX_TOTAL_UTIL = 1;
    localparam logic [6:0]  RST_TASK_COUNT = 7'd4;
    localparam logic [31:0] RST_TOTAL_UTIL = 32'h0100_0000;
    // Largest task count; the 6-bit task index and the 7-bit divisor are sized for it.
    localparam logic [6:0]  MAX_TASKS      = 7'd64;

    // 2^(-2^-j) in Q1.31 for j = 1..30, each the floor square root of the one before.
    function automatic logic [31:0] root_const(input logic [4:0] j);
        logic [63:0] t;
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        t = 64'd1 << 30;
        for (int i = 1; i <= 30; i++) begin
            v   = t << 31;
            res = '0;
            b   = 64'd1 << 62;
            for (int s = 0; s < 32; s++) begin
                if (b != 0) begin
                    if (v >= res + b) begin
                        v   = v - (res + b);
                        res = (res >> 1) + b;
                    end else begin
                        res = res >> 1;
                    end
                    b = b >> 2;
                end
            end
            t = res;
            if (i == int'(j)) begin
                return t[31:0];
            end
        end
        return 32'h8000_0000;
    endfunction

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOG,
        ST_DIV,
        ST_EXP,
        ST_MUL,
        ST_OUT0,
        ST_OUT1
    } t_state;

endpackage

>>> rtl/core/uusplit_if.sv
// ----------------------------------------------------------------------------
// Stream interfaces
// Valid/ready channels for samples and shares.
// ----------------------------------------------------------------------------
interface uusplit_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] random_sample;
    modport source (output valid, output random_sample, input ready);
    modport sink   (input valid, input random_sample, output ready);
endinterface

interface uusplit_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] share;
    logic [5:0]  task_number;
    logic        last;
    modport source (output valid, output share, output task_number, output last,
                    input ready);
    modport sink   (input valid, input share, input task_number, input last,
                    output ready);
endinterface

>>> rtl/core/uunifast_utilization_split.sv
// Each share takes 30 log2 squarings, 36 divide steps, 30 exp2 steps and one final
// multiply, then the output handshake.
// A new sample is taken only in idle, once the share (and any last share of a set) is out;
// the log2 and exp2 steps and the final multiply share one multiplier, divide runs between.
// Reset (synchronous, active low) restores task_count 4, total 1.0 and an empty set.
// ----------------------------------------------------------------------------
// UUniFast utilization split
// Splits a configured total into random shares, one share per request, two for the last.
// ----------------------------------------------------------------------------
module uunifast_utilization_split (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    uusplit_in_if.sink          i_in,
    uusplit_out_if.source       o_out
);

    logic [6:0]  r_task_count;
    logic [31:0] r_total;
    logic [31:0] r_rem;
    logic [5:0]  r_tidx;
    uusplit_pkg::t_state r_state, n_state;

    logic [6:0]  r_n;          // divisor count - index
    logic [5:0]  r_step;
    logic [31:0] r_m;          // Q2.30 mantissa
    logic [35:0] r_mag;        // Q6.30 magnitude, becomes quotient
    logic [6:0]  r_part;       // division partial remainder
    logic [31:0] r_x;          // Q1.31 factor
    logic        r_zero;
    logic        r_final;
    logic [31:0] r_share;
    logic [31:0] r_next;

    // Clamped count.
    logic [6:0] w_cnt;
    always_comb begin
        w_cnt = r_task_count;
        if (w_cnt < 7'd2) w_cnt = 7'd2;
        if (w_cnt > uusplit_pkg::MAX_TASKS) w_cnt = uusplit_pkg::MAX_TASKS;
    end

    // Shared multiplier.
    logic [31:0] w_ma, w_mb;
    logic [63:0] w_prod;
    always_comb begin
        unique case (r_state)
            uusplit_pkg::ST_LOG: begin w_ma = r_m; w_mb = r_m; end
            uusplit_pkg::ST_EXP: begin
                w_ma = r_x; w_mb = uusplit_pkg::root_const(r_step[4:0] + 5'd1);
            end
            uusplit_pkg::ST_MUL: begin w_ma = r_rem; w_mb = r_x; end
            default:             begin w_ma = r_m; w_mb = r_m; end
        endcase
        w_prod = w_ma * w_mb;
    end

    // Leading one position.
    logic [4:0]  w_p;
    logic [31:0] w_mant;
    always_comb begin
        w_p = '0;
        for (int i = 0; i < 32; i++) begin
            if (i_in.random_sample[i]) w_p = 5'(i);
        end
        if (w_p == 5'd31) w_mant = {1'b0, i_in.random_sample[31:1]};
        else w_mant = i_in.random_sample << (5'd30 - w_p);
    end

    logic [6:0]  w_trial;
    logic [7:0]  w_sub;
    logic [33:0] w_sq;
    assign w_trial = {r_part[5:0], r_mag[35]};
    assign w_sub   = {1'b0, w_trial} - {1'b0, r_n};
    assign w_sq    = w_prod[63:30];

    assign i_in.ready  = (r_state == uusplit_pkg::ST_IDLE);
    assign o_out.valid = (r_state == uusplit_pkg::ST_OUT0) ||
                         (r_state == uusplit_pkg::ST_OUT1);
    assign o_out.share = (r_state == uusplit_pkg::ST_OUT1) ? r_next : r_share;
    assign o_out.task_number = (r_state == uusplit_pkg::ST_OUT1) ?
                               6'(w_cnt - 7'd1) : r_tidx;
    assign o_out.last  = (r_state == uusplit_pkg::ST_OUT1);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            uusplit_pkg::ST_IDLE: if (i_in.valid) n_state = uusplit_pkg::ST_LOG;
            uusplit_pkg::ST_LOG:  if (r_step == 6'd29) n_state = uusplit_pkg::ST_DIV;
            uusplit_pkg::ST_DIV:  if (r_step == 6'd35) n_state = uusplit_pkg::ST_EXP;
            uusplit_pkg::ST_EXP:  if (r_step == 6'd29) n_state = uusplit_pkg::ST_MUL;
            uusplit_pkg::ST_MUL:  n_state = uusplit_pkg::ST_OUT0;
            uusplit_pkg::ST_OUT0: if (o_out.ready)
                n_state = r_final ? uusplit_pkg::ST_OUT1 : uusplit_pkg::ST_IDLE;
            uusplit_pkg::ST_OUT1: if (o_out.ready) n_state = uusplit_pkg::ST_IDLE;
            default:              n_state = uusplit_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= uusplit_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // Configuration and set state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_count <= uusplit_pkg::RST_TASK_COUNT;
            r_total      <= uusplit_pkg::RST_TOTAL_UTIL;
            r_rem        <= '0;
            r_tidx       <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == 1'(uusplit_pkg::IDX_TASK_COUNT))
                    r_task_count <= i_cfg_data[6:0];
                else
                    r_total <= i_cfg_data;
            end
            if (r_state == uusplit_pkg::ST_IDLE && i_in.valid) begin
                if ({1'b0, r_tidx} >= w_cnt - 7'd1) begin
                    r_tidx <= '0;
                    r_rem  <= r_total;
                end else if (r_tidx == '0) begin
                    r_rem <= r_total;
                end
            end
            if (r_state == uusplit_pkg::ST_OUT0 && o_out.ready) begin
                r_rem  <= r_next;
                r_tidx <= r_final ? 6'd0 : r_tidx + 6'd1;
            end
        end
    end

    // Datapath sequencing.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            uusplit_pkg::ST_IDLE: begin
                r_step <= '0;
                r_m    <= w_mant;
                r_mag  <= {6'(6'd32 - {1'b0, w_p}), 30'd0};
                r_zero <= (i_in.random_sample == '0);
                r_part <= '0;
                r_x    <= 32'h8000_0000;
                if ({1'b0, r_tidx} >= w_cnt - 7'd1) begin
                    r_n     <= w_cnt;
                    r_final <= (w_cnt == 7'd2);
                end else begin
                    r_n     <= w_cnt - {1'b0, r_tidx};
                    r_final <= ({1'b0, r_tidx} == w_cnt - 7'd2);
                end
            end
            uusplit_pkg::ST_LOG: begin
                r_step <= (r_step == 6'd29) ? 6'd0 : r_step + 6'd1;
                if (w_sq[31] || w_sq[32] || w_sq[33]) begin
                    r_m   <= w_sq[32:1];
                    r_mag <= r_mag - (36'd1 << (5'd29 - r_step[4:0]));
                end else begin
                    r_m <= w_sq[31:0];
                end
            end
            uusplit_pkg::ST_DIV: begin
                r_step <= (r_step == 6'd35) ? 6'd0 : r_step + 6'd1;
                if (!w_sub[7]) begin
                    r_part <= w_sub[6:0];
                    r_mag  <= {r_mag[34:0], 1'b1};
                end else begin
                    r_part <= w_trial;
                    r_mag  <= {r_mag[34:0], 1'b0};
                end
            end
            uusplit_pkg::ST_EXP: begin
                if (r_step == 6'd29) begin
                    // Last fraction bit, then the integer shift and the zero sample.
                    r_step <= '0;
                    if (r_zero || r_mag[35]) begin
                        r_x <= '0;
                    end else if (r_mag[0]) begin
                        r_x <= w_prod[62:31] >> r_mag[34:30];
                    end else begin
                        r_x <= r_x >> r_mag[34:30];
                    end
                end else begin
                    r_step <= r_step + 6'd1;
                    if (r_mag[5'd29 - r_step[4:0]]) r_x <= w_prod[62:31];
                end
            end
            uusplit_pkg::ST_MUL: begin
                r_next  <= w_prod[62:31];
                r_share <= r_rem - w_prod[62:31];
            end
            default: begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != uusplit_pkg::ST_IDLE) |-> !i_in.ready)
        else $error("ready while busy");
    a_last_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == uusplit_pkg::ST_OUT1) |-> $past(r_state) == uusplit_pkg::ST_OUT0 ||
        $past(r_state) == uusplit_pkg::ST_OUT1)
        else $error("last share out of order");
    a_share_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == uusplit_pkg::ST_OUT0) |-> r_next <= r_rem)
        else $error("next exceeds remainder");
`endif

endmodule
